// ----- rtl/core/cfpf_pkg.sv -----
package cfpf_pkg;

    // Field widths
    localparam int TICK_W   = 32;
    localparam int BUS_W    = 2;
    localparam int ID_W     = 29;
    localparam int DLC_W    = 4;
    localparam int DATA_W   = 64;
    localparam int PERIOD_W = 16;

    // Stream and configuration port widths
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 72;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Only frames seen on this bus are taken
    localparam logic [BUS_W-1:0] BUS_ACCEPTED = 2'd1;

    // Register reset values
    localparam logic [ID_W-1:0]     MATCH_ID_RST  = 29'd0;
    localparam logic [DLC_W-1:0]    MATCH_DLC_RST = 4'd8;
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd100;
    localparam logic [PERIOD_W-1:0] TIMEOUT_RST   = 16'd500;

    typedef enum logic {
        OP_FRAME    = 1'b0,
        OP_PERIODIC = 1'b1
    } opcode_e;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MATCH_ID      = 8'd0,
        REG_MATCH_DLC     = 8'd1,
        REG_RESEND_PERIOD = 8'd2,
        REG_FRESH_TIMEOUT = 8'd3
    } reg_index_e;

    typedef struct packed {
        logic [ID_W-1:0]     match_id;
        logic [DLC_W-1:0]    match_dlc;
        logic [PERIOD_W-1:0] resend_period_ms;
        logic [PERIOD_W-1:0] fresh_timeout_ms;
    } cfg_t;

endpackage

// ----- rtl/core/cfpf_cfg_regs.sv -----
module cfpf_cfg_regs import cfpf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MATCH_ID:      cfg_next.match_id         = cfg_data[ID_W-1:0];
                REG_MATCH_DLC:     cfg_next.match_dlc        = cfg_data[DLC_W-1:0];
                REG_RESEND_PERIOD: cfg_next.resend_period_ms = cfg_data[PERIOD_W-1:0];
                REG_FRESH_TIMEOUT: cfg_next.fresh_timeout_ms = cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_id         <= MATCH_ID_RST;
            cfg_reg.match_dlc        <= MATCH_DLC_RST;
            cfg_reg.resend_period_ms <= PERIOD_RST;
            cfg_reg.fresh_timeout_ms <= TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/can_frame_periodic_forwarder.sv -----
// Forwards one configured CAN status frame and repeats it periodically. Each input item is a
// received frame (tuser 0) or a periodic task call (tuser 1), both stamped with the current
// millisecond tick. A matching frame from bus 1 is stored and forwarded at once; a periodic
// call that has reached the resend time resends the stored frame while it is still fresh.
// Every item yields exactly one result item. One item is taken per clock unless the m_ side
// stalls; an item is held in the input register, then its result goes to the result register
// and is presented on the m_ side. The stored frame and schedule are updated in the single
// stage between them, so back-to-back items always see the state left by the item before.
// Registers must be written only while idle; the block itself does not enforce it.
module can_frame_periodic_forwarder import cfpf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_tick[31:0], source_bus[33:32], frame_id[62:34], frame_dlc[66:63],
    // frame_data[130:67], zero fill above
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,   // opcode
    // Result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // send_data[63:0], send_dlc[67:64], is_fresh[68], zero fill above
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tuser,   // send
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;

    cfpf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register
    logic              in_valid_reg;
    opcode_e           in_op_reg;
    logic [TICK_W-1:0] in_now_reg;
    logic [BUS_W-1:0]  in_bus_reg;
    logic [ID_W-1:0]   in_id_reg;
    logic [DLC_W-1:0]  in_dlc_reg;
    logic [DATA_W-1:0] in_data_reg;

    // Forwarder state
    logic [DATA_W-1:0] stored_payload_reg;
    logic [DLC_W-1:0]  stored_length_reg;
    logic [TICK_W-1:0] rx_stamp_reg;
    logic              have_frame_reg;
    logic [TICK_W-1:0] next_resend_reg;

    // Result register
    logic              m_valid_reg;
    logic              m_send_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic [DLC_W-1:0]  m_dlc_reg;
    logic              m_fresh_reg;

    logic advance;
    logic take;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_op_reg   <= opcode_e'(s_tuser);
            in_now_reg  <= s_tdata[31:0];
            in_bus_reg  <= s_tdata[33:32];
            in_id_reg   <= s_tdata[62:34];
            in_dlc_reg  <= s_tdata[66:63];
            in_data_reg <= s_tdata[130:67];
        end
    end

    // Processing stage
    logic              is_periodic;
    logic              frame_match;
    logic [TICK_W-1:0] age;
    logic              fresh_old;
    logic [TICK_W-1:0] resend_eff;
    logic [TICK_W-1:0] lateness;
    logic              due;
    logic [TICK_W-1:0] next_sched;
    logic              send_now;

    always_comb begin
        is_periodic = (in_op_reg == OP_PERIODIC);
        frame_match = !is_periodic && (in_bus_reg == BUS_ACCEPTED)
                      && (in_id_reg == cfg.match_id) && (in_dlc_reg == cfg.match_dlc);
        // freshness against the state before this item
        age         = in_now_reg - rx_stamp_reg;
        fresh_old   = have_frame_reg
                      && (age <= {{(TICK_W-PERIOD_W){1'b0}}, cfg.fresh_timeout_ms});
        // unscheduled resend counts as due now; wrap-aware reached test
        resend_eff  = (next_resend_reg == '0) ? in_now_reg : next_resend_reg;
        lateness    = in_now_reg - resend_eff;
        due         = is_periodic && !lateness[TICK_W-1];
        next_sched  = in_now_reg + {{(TICK_W-PERIOD_W){1'b0}}, cfg.resend_period_ms};
        send_now    = frame_match || (due && fresh_old);
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_frame_reg  <= 1'b0;
            next_resend_reg <= '0;
        end else if (advance) begin
            if (frame_match) begin
                have_frame_reg  <= 1'b1;
                next_resend_reg <= next_sched;
            end else if (due) begin
                next_resend_reg <= next_sched;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame_match) begin
            stored_payload_reg <= in_data_reg;
            stored_length_reg  <= in_dlc_reg;
            rx_stamp_reg       <= in_now_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_send_reg  <= send_now;
            m_fresh_reg <= frame_match || fresh_old;
            if (frame_match) begin
                m_data_reg <= in_data_reg;
                m_dlc_reg  <= in_dlc_reg;
            end else if (send_now) begin
                m_data_reg <= stored_payload_reg;
                m_dlc_reg  <= stored_length_reg;
            end else begin
                m_data_reg <= '0;
                m_dlc_reg  <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_send_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-DLC_W-1){1'b0}}, m_fresh_reg, m_dlc_reg, m_data_reg};

    // Checks
    a_match_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && frame_match |=> m_valid_reg && m_send_reg && m_fresh_reg && have_frame_reg)
        else $error("accepted frame not forwarded");

    a_send_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_send_reg |-> m_fresh_reg)
        else $error("frame sent while not fresh");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_send_reg |-> (m_data_reg == '0) && (m_dlc_reg == '0))
        else $error("payload present without send");

endmodule

// ----- dv/can_forwarder_checker.sv -----
module can_forwarder_checker import cfpf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        bit              send;
        bit [DATA_W-1:0] data;
        bit [DLC_W-1:0]  dlc;
        bit              fresh;
    } fwd_result_t;

    // Shadow copy of the registers and of the stored frame
    cfg_t              cfg;
    bit [DATA_W-1:0]   stored_payload;
    bit [DLC_W-1:0]    stored_length;
    bit [TICK_W-1:0]   rx_stamp;
    bit                have_frame;
    bit [TICK_W-1:0]   next_resend;

    fwd_result_t       pending_results[$];
    fwd_result_t       want;
    int                mismatches = 0;

    // Stored frame is fresh while its age, modulo 2^32, is within the timeout
    function automatic bit fresh_at(input bit [TICK_W-1:0] now);
        bit [TICK_W-1:0] age;
        age = now - rx_stamp;
        return have_frame && (age <= TICK_W'(cfg.fresh_timeout_ms));
    endfunction

    // Advances the shadow state by one item and returns the result it causes
    function automatic fwd_result_t predict_forward(input opcode_e op,
                                                    input bit [TICK_W-1:0] now,
                                                    input bit [BUS_W-1:0] bus,
                                                    input bit [ID_W-1:0] id,
                                                    input bit [DLC_W-1:0] dlc,
                                                    input bit [DATA_W-1:0] data);
        fwd_result_t     r;
        bit [TICK_W-1:0] lag;
        r = '0;
        if (op == OP_FRAME) begin
            if (bus == BUS_ACCEPTED && id == cfg.match_id && dlc == cfg.match_dlc) begin
                stored_payload = data;
                stored_length  = dlc;
                rx_stamp       = now;
                have_frame     = 1'b1;
                next_resend    = now + TICK_W'(cfg.resend_period_ms);
                r.send         = 1'b1;
            end
        end else begin
            // unscheduled: a zero resend time means due right now
            if (next_resend == '0)
                next_resend = now;
            lag = now - next_resend;
            if (!lag[TICK_W-1]) begin
                r.send      = fresh_at(now);
                next_resend = now + TICK_W'(cfg.resend_period_ms);
            end
        end
        if (r.send) begin
            r.data = stored_payload;
            r.dlc  = stored_length;
        end
        r.fresh = fresh_at(now);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.match_id         = MATCH_ID_RST;
            cfg.match_dlc        = MATCH_DLC_RST;
            cfg.resend_period_ms = PERIOD_RST;
            cfg.fresh_timeout_ms = TIMEOUT_RST;
            stored_payload       = '0;
            stored_length        = '0;
            rx_stamp             = '0;
            have_frame           = 1'b0;
            next_resend          = '0;
            pending_results.delete();
        end else begin
            // Result item: compare with the oldest expectation
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result item arrived with no expectation pending");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("send", DATA_W'(want.send), DATA_W'(m_tuser));
                    check_field("send_data", want.data, m_tdata[63:0]);
                    check_field("send_dlc", DATA_W'(want.dlc), DATA_W'(m_tdata[67:64]));
                    check_field("is_fresh", DATA_W'(want.fresh), DATA_W'(m_tdata[68]));
                    check_field("zero fill", '0, DATA_W'(m_tdata[M_TDATA_W-1:69]));
                end
            end
            // Register write; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MATCH_ID:      cfg.match_id         = cfg_data[ID_W-1:0];
                    REG_MATCH_DLC:     cfg.match_dlc        = cfg_data[DLC_W-1:0];
                    REG_RESEND_PERIOD: cfg.resend_period_ms = cfg_data[PERIOD_W-1:0];
                    REG_FRESH_TIMEOUT: cfg.fresh_timeout_ms = cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            // Input item: now[31:0] bus[33:32] id[62:34] dlc[66:63] data[130:67]
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_forward(opcode_e'(s_tuser),
                                                          s_tdata[31:0], s_tdata[33:32],
                                                          s_tdata[62:34], s_tdata[66:63],
                                                          s_tdata[130:67]));
        end
        results_due <= pending_results.size();
        fail_count  <= mismatches;
    end

endmodule

// ----- dv/tb_can_frame_periodic_forwarder.sv -----
module tb_can_frame_periodic_forwarder import cfpf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int results_due;
    int cycle_count = 0;
    int tx_idle_pct;
    int rx_stall_pct;

    // Current register values, used to aim the random items
    bit [ID_W-1:0]     cur_id;
    bit [DLC_W-1:0]    cur_dlc;
    bit [PERIOD_W-1:0] cur_period;
    bit [TICK_W-1:0]   tick_now;

    can_frame_periodic_forwarder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    can_forwarder_checker fwd_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bit [DATA_W-1:0] rand_payload();
        return {$urandom(), $urandom()};
    endfunction

    // One input item, after a random idle gap on the sender side
    task automatic send_item(input opcode_e op, input bit [TICK_W-1:0] now,
                             input bit [BUS_W-1:0] bus, input bit [ID_W-1:0] id,
                             input bit [DLC_W-1:0] dlc, input bit [DATA_W-1:0] data);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, data, dlc, id, bus, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_settings(input bit [ID_W-1:0] id, input bit [DLC_W-1:0] dlc,
                                  input bit [PERIOD_W-1:0] period,
                                  input bit [PERIOD_W-1:0] timeout);
        wait_idle();
        write_reg(REG_MATCH_ID, CFG_DATA_W'(id));
        write_reg(REG_MATCH_DLC, CFG_DATA_W'(dlc));
        write_reg(REG_RESEND_PERIOD, CFG_DATA_W'(period));
        write_reg(REG_FRESH_TIMEOUT, CFG_DATA_W'(timeout));
        // index past the register list, must be ignored
        write_reg(CFG_INDEX_W'($urandom_range(4, 255)), $urandom());
        cfg_valid  <= 1'b0;
        cur_id     = id;
        cur_dlc    = dlc;
        cur_period = period;
    endtask

    // Mostly matching frames and periodic calls on a walking tick, some near misses and noise
    task automatic run_phase(input int count, input bit pause_midway);
        int pick;
        int step_max;
        tick_now = $urandom();
        step_max = int'(cur_period) + int'(cur_period) / 2 + 2;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2)
                wait_idle();
            if ($urandom_range(19) == 0)
                tick_now += $urandom();
            else
                tick_now += TICK_W'($urandom_range(0, step_max));
            pick = $urandom_range(99);
            if (pick < 40)
                send_item(OP_FRAME, tick_now, BUS_ACCEPTED, cur_id, cur_dlc, rand_payload());
            else if (pick < 85)
                send_item(OP_PERIODIC, tick_now, BUS_W'($urandom_range(3)), ID_W'($urandom()),
                          DLC_W'($urandom_range(15)), rand_payload());
            else if (pick < 88)
                send_item(OP_FRAME, tick_now, BUS_ACCEPTED ^ BUS_W'($urandom_range(1, 3)),
                          cur_id, cur_dlc, rand_payload());
            else if (pick < 91)
                send_item(OP_FRAME, tick_now, BUS_ACCEPTED,
                          cur_id ^ (ID_W'(1) << $urandom_range(ID_W - 1)), cur_dlc,
                          rand_payload());
            else if (pick < 94)
                send_item(OP_FRAME, tick_now, BUS_ACCEPTED, cur_id,
                          cur_dlc ^ (DLC_W'(1) << $urandom_range(DLC_W - 1)), rand_payload());
            else
                send_item(OP_FRAME, $urandom(), BUS_W'($urandom_range(3)), ID_W'($urandom()),
                          DLC_W'($urandom_range(15)), rand_payload());
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        cur_id       = MATCH_ID_RST;
        cur_dlc      = MATCH_DLC_RST;
        cur_period   = PERIOD_RST;
        tick_now     = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings: id 0, dlc 8, period 100, timeout 500
        // periodic call right after reset: unscheduled, due, nothing stored
        send_item(OP_PERIODIC, 32'h10, 2'd3, 29'h1FFF_FFFF, 4'hF, '1);
        send_item(OP_FRAME, 32'h20, 2'd1, 29'h0, 4'd8, '1);
        // rejected frames: wrong bus, id, dlc
        send_item(OP_FRAME, 32'h21, 2'd0, 29'h0, 4'd8, 64'h0);
        send_item(OP_FRAME, 32'h22, 2'd2, 29'h0, 4'd8, 64'h0);
        send_item(OP_FRAME, 32'h23, 2'd3, 29'h0, 4'd8, 64'h0);
        send_item(OP_FRAME, 32'h24, 2'd1, 29'h1FFF_FFFF, 4'd8, 64'h0);
        send_item(OP_FRAME, 32'h25, 2'd1, 29'h0, 4'hF, 64'h0);
        send_item(OP_FRAME, 32'h26, 2'd1, 29'h0, 4'd0, 64'h0);
        // not yet due, then due and fresh, then not yet due again, then due but stale
        send_item(OP_PERIODIC, 32'h52, 2'd0, 29'h0, 4'd0, 64'h0);
        send_item(OP_PERIODIC, 32'h84, 2'd1, 29'h0, 4'd8, '1);
        send_item(OP_PERIODIC, 32'hE7, 2'd2, 29'h155, 4'd3, rand_payload());
        send_item(OP_PERIODIC, 32'h3A0, 2'd0, 29'h0, 4'd0, 64'h0);
        // schedule crossing the signed half range
        send_item(OP_FRAME, 32'h7FFF_FFF0, 2'd1, 29'h0, 4'd8, 64'h0);
        send_item(OP_PERIODIC, 32'h8000_0060, 2'd0, 29'h0, 4'd0, 64'h0);
        send_item(OP_PERIODIC, 32'h0000_0001, 2'd0, 29'h0, 4'd0, 64'h0);
        // frame that leaves the resend time at zero, then tick wrap
        send_item(OP_FRAME, 32'hFFFF_FF9C, 2'd1, 29'h0, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_item(OP_PERIODIC, 32'h0000_0005, 2'd0, 29'h0, 4'd0, 64'h0);
        send_item(OP_FRAME, 32'hFFFF_FFFF, 2'd1, 29'h0, 4'd8, rand_payload());
        send_item(OP_PERIODIC, 32'h0000_0063, 2'd0, 29'h0, 4'd0, 64'h0);
        // age exactly at the timeout, then one past it
        send_item(OP_PERIODIC, 32'h0000_01F3, 2'd0, 29'h0, 4'd0, 64'h0);
        send_item(OP_PERIODIC, 32'h0000_01F4, 2'd0, 29'h0, 4'd0, 64'h0);

        // Random phases, each with its own settings and idle pattern
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    apply_settings(ID_W'($urandom()), DLC_W'($urandom_range(8)),
                                   PERIOD_W'($urandom_range(1, 300)),
                                   PERIOD_W'($urandom_range(600)));
                    tx_idle_pct  = 77;
                    rx_stall_pct = 0;
                end
                2: begin
                    apply_settings('1, '0, PERIOD_W'(1), '0);
                    tx_idle_pct  = 0;
                    rx_stall_pct = 77;
                end
                3: begin
                    apply_settings('0, DLC_W'(8), '1, '1);
                    tx_idle_pct  = 21;
                    rx_stall_pct = 21;
                end
                4: begin
                    // zero period and a length code above 8
                    apply_settings(ID_W'($urandom()), DLC_W'($urandom_range(9, 15)), '0,
                                   PERIOD_W'($urandom_range(200)));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                default: begin
                    apply_settings(ID_W'($urandom()), DLC_W'($urandom_range(8)),
                                   PERIOD_W'($urandom_range(1, 1000)), PERIOD_W'($urandom()));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 77;
                end
            endcase
            run_phase(190, p == 3);
        end

        // Drain and give the verdict
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && results_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
